// ----- hw/rtl/hfs_pkg.sv -----
// shared types, register codes, widths and reset values of the humidity fan sequencer
package hfs_pkg;

	localparam int TIME_BITS_DEF = 32;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int TRIG_W   = 7;
	localparam int ON_W     = 32;
	localparam int PAUSE_W  = 30;
	localparam int SW_W     = 12;
	localparam int MAX_W    = 4;
	localparam int MULT_W   = 3;
	localparam int GRACE_W  = 20;
	localparam int HUM_W    = 14;
	localparam int CNT_W    = 4;
	localparam int WIN_W    = PAUSE_W + MULT_W;
	localparam int WINSUM_W = WIN_W + 1;

	localparam logic [TRIG_W-1:0]  TRIG_RST  = TRIG_W'(80);
	localparam logic [ON_W-1:0]    ON_RST    = ON_W'(10 * 1000);
	localparam logic [PAUSE_W-1:0] PAUSE_RST = PAUSE_W'(30 * 60 * 1000);
	localparam logic [SW_W-1:0]    SW_RST    = SW_W'(100);
	localparam logic [MAX_W-1:0]   MAX_RST   = MAX_W'(7);
	localparam logic [MULT_W-1:0]  MULT_RST  = MULT_W'(7);
	localparam logic [GRACE_W-1:0] GRACE_RST = GRACE_W'(1000 * 60);

	localparam logic [HUM_W-1:0] HUM_SCALE = HUM_W'(100);
	localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

	localparam int OUT_DATA_W = 8;
	localparam int OUT_FAN    = 0;
	localparam int OUT_LOCK   = 1;
	localparam int OUT_PAUSE  = 2;
	localparam int OUT_CNT_LO = 3;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_TRIGGER  = 3'd0,
		CFG_ON_TIME  = 3'd1,
		CFG_PAUSE    = 3'd2,
		CFG_SWITCH   = 3'd3,
		CFG_MAX_ACT  = 3'd4,
		CFG_WIN_MULT = 3'd5,
		CFG_GRACE    = 3'd6
	} hfs_cfg_idx_t;

	// per-sample classification passed from front to back
	typedef struct packed {
		logic ok;
		logic hum_hi;
		logic man_req;
	} hfs_flags_t;

	localparam int FLAGS_W = $bits(hfs_flags_t);

	typedef struct packed {
		logic [TRIG_W-1:0] trig;
		logic [SW_W-1:0]   sw_thr;
	} hfs_front_cfg_t;

	typedef struct packed {
		logic [ON_W-1:0]     on_time;
		logic [PAUSE_W-1:0]  pause_time;
		logic [MAX_W-1:0]    max_act;
		logic [WIN_W-1:0]    win;
		logic [WINSUM_W-1:0] winsum;
	} hfs_back_cfg_t;

endpackage

// ----- hw/rtl/hfs_front.sv -----
// front stage: registers a sample and classifies it against the thresholds
module hfs_front
	import hfs_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [TIME_BITS-1:0]         in_time,
	input  logic [HUM_W-1:0]             in_hum,
	input  logic [SW_W-1:0]              in_switch,
	input  logic                         in_web,
	input  logic                         in_ok,
	input  hfs_front_cfg_t               fcfg,
	output logic                         push_valid,
	input  logic                         push_ready,
	output logic [TIME_BITS+FLAGS_W-1:0] push_data
);

	logic                 valid_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic [HUM_W-1:0]     hum_s1;
	logic [SW_W-1:0]      sw_s1;
	logic                 web_s1;
	logic                 ok_s1;
	logic [HUM_W-1:0]     hum_limit;
	hfs_flags_t           flags;

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			time_s1 <= in_time;
			hum_s1  <= in_hum;
			sw_s1   <= in_switch;
			web_s1  <= in_web;
			ok_s1   <= in_ok;
		end
	end

	always_comb begin
		hum_limit     = HUM_W'(fcfg.trig) * HUM_SCALE;
		flags.ok      = ok_s1;
		flags.hum_hi  = hum_s1 > hum_limit;
		flags.man_req = web_s1 || (ok_s1 && (sw_s1 <= fcfg.sw_thr));
	end

	assign push_data = {time_s1, flags};

endmodule

// ----- hw/rtl/hfs_queue.sv -----
// short fifo between the classifying front and the sequencing back
module hfs_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hw/rtl/hfs_back.sv -----
// back stage: fan run, pause, activation window and lockout state, plus output register
module hfs_back
	import hfs_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pop_valid,
	output logic                         pop_ready,
	input  logic [TIME_BITS+FLAGS_W-1:0] pop_data,
	input  hfs_back_cfg_t                bcfg,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [OUT_DATA_W-1:0]        out_data
);

	localparam int CMP_W = (TIME_BITS > WINSUM_W) ? TIME_BITS : WINSUM_W;

	logic                  fan_q, vent_q, run_started_q, pause_q;
	logic                  win_open_q, manual_q, enabled_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TIME_BITS-1:0]  run_start_q, win_start_q;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic                  fan_d, vent_d, run_started_d, pause_d;
	logic                  win_open_d, manual_d, enabled_d;
	logic [CNT_W-1:0]      cnt_d;
	logic [TIME_BITS-1:0]  run_start_d, win_start_d;

	logic [TIME_BITS-1:0]  now;
	hfs_flags_t            flags;
	logic                  start;
	logic [TIME_BITS-1:0]  elapsed;
	logic [TIME_BITS-1:0]  run;
	logic                  fire;

	assign now   = pop_data[TIME_BITS+FLAGS_W-1:FLAGS_W];
	assign flags = hfs_flags_t'(pop_data[FLAGS_W-1:0]);
	assign fire      = pop_valid && (!out_valid_q || out_ready);
	assign pop_ready = fire;

	always_comb begin
		fan_d         = fan_q;
		vent_d        = vent_q;
		run_started_d = run_started_q;
		pause_d       = pause_q;
		win_open_d    = win_open_q;
		manual_d      = manual_q || flags.man_req;
		enabled_d     = enabled_q;
		cnt_d         = cnt_q;
		run_start_d   = run_start_q;
		win_start_d   = win_start_q;
		start         = 1'b0;
		elapsed       = '0;
		run           = '0;
		if (flags.ok && enabled_q) begin
			start = (flags.hum_hi && !vent_q) || (manual_d && !run_started_q);
			if (start) begin
				fan_d         = 1'b1;
				run_start_d   = now;
				vent_d        = 1'b1;
				manual_d      = 1'b0;
				run_started_d = 1'b1;
				win_open_d    = 1'b1;
				if (win_open_q) begin
					elapsed = now - win_start_q;
				end else begin
					win_start_d = now;
				end
				if ((CMP_W'(elapsed) <= CMP_W'(bcfg.winsum)) && (cnt_q != CNT_MAX)) begin
					cnt_d = cnt_q + 1'b1;
				end
				if (CMP_W'(elapsed) > CMP_W'(bcfg.win)) begin
					if (cnt_d >= bcfg.max_act) begin
						enabled_d = 1'b0;
						fan_d     = 1'b0;
					end
					win_open_d = 1'b0;
					cnt_d      = '0;
				end
			end else begin
				run = now - run_start_q;
			end
			if ((CMP_W'(run) >= CMP_W'(bcfg.on_time)) && vent_d && !pause_d) begin
				fan_d   = 1'b0;
				pause_d = 1'b1;
			end
			if ((CMP_W'(run) >= CMP_W'(bcfg.pause_time)) && pause_d) begin
				pause_d       = 1'b0;
				vent_d        = 1'b0;
				run_started_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_q         <= 1'b0;
			vent_q        <= 1'b0;
			run_started_q <= 1'b0;
			pause_q       <= 1'b0;
			win_open_q    <= 1'b0;
			manual_q      <= 1'b0;
			enabled_q     <= 1'b1;
			cnt_q         <= '0;
			run_start_q   <= '0;
			win_start_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (fire) begin
				fan_q         <= fan_d;
				vent_q        <= vent_d;
				run_started_q <= run_started_d;
				pause_q       <= pause_d;
				win_open_q    <= win_open_d;
				manual_q      <= manual_d;
				enabled_q     <= enabled_d;
				cnt_q         <= cnt_d;
				run_start_q   <= run_start_d;
				win_start_q   <= win_start_d;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= OUT_DATA_W'({cnt_d, pause_d, !enabled_d, fan_d});
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- hw/rtl/humidity_fan_sequencer.sv -----
// top level of the humidity fan sequencer: ports, configuration registers, front, queue, back
//
// One sample in, one result out. The block accepts a sample every clock cycle while
// s_tready is not held low by back-pressure, and returns its result through the
// front register that compares humidity and switch level against their thresholds,
// the two-entry queue, and the back, whose state update (two time subtractions and
// their compares against the run, pause and window limits) sets the sustained rate
// of one sample per cycle while m_tready is high. The front register and queue let
// further samples enter while a result waits on m_tready. Configuration writes
// are taken at any time with cfg_ready held high and also apply to samples already
// inside the block; the window limit and window plus grace are registered from the
// pause time, multiple and grace registers after a write. Once locked out, the
// block stays so until arst_n.
module humidity_fan_sequencer
	import hfs_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// time_ms, humidity_centi, switch_level, web_request, zero fill
	input  logic [(TIME_BITS + HUM_W + SW_W + 1 + 7) / 8 * 8 - 1:0] s_tdata,
	// sensor_ok
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// fan_on, locked_out, pausing, start_count, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int HUM_LO    = TIME_BITS;
	localparam int SW_LO     = HUM_LO + HUM_W;
	localparam int WEB_BIT   = SW_LO + SW_W;
	localparam int ITEM_W    = TIME_BITS + FLAGS_W;

	logic [TRIG_W-1:0]   trig_q;
	logic [ON_W-1:0]     on_time_q;
	logic [PAUSE_W-1:0]  pause_q;
	logic [SW_W-1:0]     sw_thr_q;
	logic [MAX_W-1:0]    max_act_q;
	logic [MULT_W-1:0]   mult_q;
	logic [GRACE_W-1:0]  grace_q;
	logic [WIN_W-1:0]    win_q;
	logic [WINSUM_W-1:0] winsum_q;
	logic [WIN_W-1:0]    win_prod;

	hfs_front_cfg_t      fcfg;
	hfs_back_cfg_t       bcfg;

	logic                push_valid, push_ready;
	logic [ITEM_W-1:0]   push_data;
	logic                pop_valid, pop_ready;
	logic [ITEM_W-1:0]   pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q    <= TRIG_RST;
			on_time_q <= ON_RST;
			pause_q   <= PAUSE_RST;
			sw_thr_q  <= SW_RST;
			max_act_q <= MAX_RST;
			mult_q    <= MULT_RST;
			grace_q   <= GRACE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (hfs_cfg_idx_t'(cfg_addr))
				CFG_TRIGGER: begin
					trig_q <= cfg_data[TRIG_W-1:0];
				end
				CFG_ON_TIME: begin
					on_time_q <= cfg_data[ON_W-1:0];
				end
				CFG_PAUSE: begin
					pause_q <= cfg_data[PAUSE_W-1:0];
				end
				CFG_SWITCH: begin
					sw_thr_q <= cfg_data[SW_W-1:0];
				end
				CFG_MAX_ACT: begin
					max_act_q <= cfg_data[MAX_W-1:0];
				end
				CFG_WIN_MULT: begin
					mult_q <= cfg_data[MULT_W-1:0];
				end
				CFG_GRACE: begin
					grace_q <= cfg_data[GRACE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// window length and window plus grace
	assign win_prod = WIN_W'(pause_q) * WIN_W'(mult_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= WIN_W'(PAUSE_RST) * WIN_W'(MULT_RST);
			winsum_q <= WINSUM_W'(WIN_W'(PAUSE_RST) * WIN_W'(MULT_RST)) + WINSUM_W'(GRACE_RST);
		end else begin
			win_q    <= win_prod;
			winsum_q <= WINSUM_W'(win_prod) + WINSUM_W'(grace_q);
		end
	end

	always_comb begin
		fcfg.trig        = trig_q;
		fcfg.sw_thr      = sw_thr_q;
		bcfg.on_time     = on_time_q;
		bcfg.pause_time  = pause_q;
		bcfg.max_act     = max_act_q;
		bcfg.win         = win_q;
		bcfg.winsum      = winsum_q;
	end

	hfs_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_time   (s_tdata[TIME_BITS-1:0]),
		.in_hum    (s_tdata[SW_LO-1:HUM_LO]),
		.in_switch (s_tdata[WEB_BIT-1:SW_LO]),
		.in_web    (s_tdata[WEB_BIT]),
		.in_ok     (s_tuser),
		.fcfg      (fcfg),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	hfs_queue #(
		.WIDTH(ITEM_W),
		.DEPTH(2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	hfs_back #(
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.bcfg     (bcfg),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata)
	);

	// a locked out block never drives the fan
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_LOCK] |-> !m_tdata[OUT_FAN])
		else $error("fan on while locked out");

	// the fan is off for the whole pause phase
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_PAUSE] |-> !m_tdata[OUT_FAN])
		else $error("fan on during pause");

	// a queued sample is handed to the back whenever the result slot is free
	assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid && !m_tvalid |-> pop_ready)
		else $error("back stalled with free result slot");

endmodule

// ----- tb/humidity_fan_sequencer_test.sv -----
// testbench of the humidity fan sequencer: directed and random samples checked against a local model
module humidity_fan_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hfs_pkg::*;

	localparam int TB_W = TIME_BITS_DEF;
	localparam int SAMPLE_W = 64;
	localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [TB_W-1:0]  time_ms;
		logic [HUM_W-1:0] humidity;
		logic             ok;
		logic [SW_W-1:0]  sw_level;
		logic             web;
	} sample_t;

	typedef struct packed {
		logic             fan;
		logic             locked;
		logic             pausing;
		logic [CNT_W-1:0] starts;
	} fan_status_t;

	typedef struct {
		logic [CFG_DATA_W-1:0] trig, on_time, pause, sw_thr, max_act, mult, grace;
	} reg_values_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// time_ms, humidity_centi, switch_level, web_request, zero fill
	logic [SAMPLE_W-1:0]   s_tdata = '0;
	// sensor_ok
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// fan_on, locked_out, pausing, start_count, zero fill
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register copies
	logic [TRIG_W-1:0]  cfg_trig = TRIG_RST;
	logic [ON_W-1:0]    cfg_on = ON_RST;
	logic [PAUSE_W-1:0] cfg_pause = PAUSE_RST;
	logic [SW_W-1:0]    cfg_sw = SW_RST;
	logic [MAX_W-1:0]   cfg_max = MAX_RST;
	logic [MULT_W-1:0]  cfg_mult = MULT_RST;
	logic [GRACE_W-1:0] cfg_grace = GRACE_RST;

	// sequencer state
	logic fan_drive = 1'b0;
	logic vent_active = 1'b0;
	logic run_started = 1'b0;
	logic pause_phase = 1'b0;
	logic window_open = 1'b0;
	logic manual_pending = 1'b0;
	logic enabled = 1'b1;
	logic [CNT_W-1:0] start_count = '0;
	logic [TB_W-1:0]  run_start = '0;
	logic [TB_W-1:0]  window_start = '0;

	fan_status_t     expected_status[$];
	logic [TB_W-1:0] now_ms = '0;
	bit              idle_en = 1'b1;
	int              stall_left = 0;
	int              mismatch_count = 0;
	int              samples_sent = 0;
	int              settings_loaded = 0;
	int              fan_starts = 0;

	humidity_fan_sequencer #(.TIME_BITS(TB_W)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic fan_status_t next_fan_status(sample_t s);
		logic [TB_W-1:0] elapsed, run_len;
		logic [63:0]     win;
		fan_status_t     st;
		if (s.web)
			manual_pending = 1'b1;
		if (s.ok) begin
			if (s.sw_level <= cfg_sw)
				manual_pending = 1'b1;
			if (enabled) begin
				if (((int'(s.humidity) > int'(cfg_trig) * int'(HUM_SCALE)) && !vent_active) ||
						(manual_pending && !run_started)) begin
					fan_starts++;
					fan_drive = 1'b1;
					run_start = s.time_ms;
					vent_active = 1'b1;
					manual_pending = 1'b0;
					run_started = 1'b1;
					if (!window_open) begin
						window_open = 1'b1;
						window_start = s.time_ms;
					end
					elapsed = s.time_ms - window_start;
					win = 64'(cfg_pause) * 64'(cfg_mult);
					// late start within grace is counted before the window closes
					if (64'(elapsed) <= win + 64'(cfg_grace) && start_count != CNT_MAX)
						start_count++;
					if (64'(elapsed) > win) begin
						if (start_count >= cfg_max) begin
							enabled = 1'b0;
							fan_drive = 1'b0;
						end
						window_open = 1'b0;
						start_count = '0;
					end
				end
				run_len = s.time_ms - run_start;
				if (run_len >= cfg_on && vent_active && !pause_phase) begin
					fan_drive = 1'b0;
					pause_phase = 1'b1;
				end
				if (64'(run_len) >= 64'(cfg_pause) && pause_phase) begin
					pause_phase = 1'b0;
					vent_active = 1'b0;
					run_started = 1'b0;
				end
			end
		end
		st.fan = fan_drive;
		st.locked = !enabled;
		st.pausing = pause_phase;
		st.starts = start_count;
		return st;
	endfunction

	function automatic sample_t timed(logic [TB_W-1:0] delta, int hum, bit ok, int sw, bit web);
		sample_t s;
		now_ms += delta;
		s.time_ms = now_ms;
		s.humidity = HUM_W'(hum);
		s.ok = ok;
		s.sw_level = SW_W'(sw);
		s.web = web;
		return s;
	endfunction

	function automatic sample_t random_sample(int step_max);
		logic [TB_W-1:0] delta;
		int hum, sw;
		// rare far jumps move every time bit and wrap the differences
		if ($urandom_range(0, 63) == 0)
			delta = $urandom();
		else
			delta = $urandom_range(0, step_max);
		if ($urandom_range(0, 1) == 1) begin
			hum = $urandom_range(0, 10000);
		end else begin
			hum = int'(cfg_trig) * 100 + int'($urandom_range(0, 100)) - 50;
			if (hum < 0)
				hum = 0;
			if (hum > 10000)
				hum = 10000;
		end
		if (cfg_sw < SW_W'(4095) && $urandom_range(0, 7) != 0)
			sw = $urandom_range(int'(cfg_sw) + 1, 4095);
		else
			sw = $urandom_range(0, int'(cfg_sw));
		return timed(delta, hum, $urandom_range(0, 7) != 0, sw, $urandom_range(0, 9) == 0);
	endfunction

	task automatic send_sample(sample_t s);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= s.ok;
		s_tdata <= SAMPLE_W'({s.web, s.sw_level, s.humidity, s.time_ms});
		do @(posedge clk); while (!s_tready);
		expected_status.push_back(next_fan_status(s));
		samples_sent++;
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (addr)
			CFG_TRIGGER:  cfg_trig = data[TRIG_W-1:0];
			CFG_ON_TIME:  cfg_on = data[ON_W-1:0];
			CFG_PAUSE:    cfg_pause = data[PAUSE_W-1:0];
			CFG_SWITCH:   cfg_sw = data[SW_W-1:0];
			CFG_MAX_ACT:  cfg_max = data[MAX_W-1:0];
			CFG_WIN_MULT: cfg_mult = data[MULT_W-1:0];
			CFG_GRACE:    cfg_grace = data[GRACE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_status.size() != 0);
	endtask

	task automatic load_setting(reg_values_t v, bit poke_unused);
		wait_drained();
		write_reg(CFG_TRIGGER, v.trig);
		write_reg(CFG_ON_TIME, v.on_time);
		write_reg(CFG_PAUSE, v.pause);
		write_reg(CFG_SWITCH, v.sw_thr);
		write_reg(CFG_MAX_ACT, v.max_act);
		write_reg(CFG_WIN_MULT, v.mult);
		write_reg(CFG_GRACE, v.grace);
		if (poke_unused)
			write_reg(CFG_UNUSED, '0);
		cfg_valid <= 1'b0;
		@(posedge clk);
		settings_loaded++;
	endtask

	task automatic test_reset_defaults();
		send_sample(timed(0, 0, 1, 4095, 0));
		// bad sample still latches the web request
		send_sample(timed(5, 9000, 0, 0, 1));
		send_sample(timed(5, 0, 1, 4095, 0));
		send_sample(timed(10000, 8000, 1, 4095, 0));
		send_sample(timed(1789990, 10000, 1, 4095, 0));
		send_sample(timed(5, 8001, 1, 4095, 0));
		send_sample(timed(1, 8001, 1, 4095, 0));
		now_ms = '1;
		send_sample(timed(0, 0, 1, 0, 0));
		send_sample(timed(1, 10000, 1, 4095, 1));
	endtask

	task automatic test_register_extremes();
		reg_values_t v;
		v = '{trig: 100, on_time: 32'hFFFF_FFFF, pause: 600000000, sw_thr: 4095,
			max_act: 15, mult: 7, grace: 600000};
		load_setting(v, 1'b0);
		send_sample(timed(1, 10000, 1, 4095, 0));
		send_sample(timed(600000000, 0, 1, 4095, 0));
		send_sample(timed(32'hFFFF_FFFF, 10000, 1, 0, 1));
		send_sample(timed(32'd4200600000, 0, 1, 4095, 0));
		// every register keeps its low bits; the unused index is dropped
		v = '{trig: '1, on_time: '1, pause: '1, sw_thr: '1, max_act: '1, mult: '1, grace: '1};
		load_setting(v, 1'b1);
		send_sample(timed(1, 10000, 1, 4095, 0));
		send_sample(timed(32'h8000_0000, 10000, 1, 4095, 1));
		send_sample(timed(32'h7FFF_FFFF, 0, 0, 0, 0));
		send_sample(timed(1, 5000, 1, 100, 0));
		v = '{trig: 0, on_time: 0, pause: 0, sw_thr: 0, max_act: 15, mult: 1, grace: 0};
		load_setting(v, 1'b0);
		send_sample(timed(1, 0, 1, 1, 0));
		send_sample(timed(1, 1, 1, 1, 0));
		send_sample(timed(0, 1, 1, 0, 0));
		send_sample(timed(1, 1, 1, 4095, 1));
		send_sample(timed(2, 0, 1, 0, 0));
	endtask

	task automatic test_random_settings();
		reg_values_t v;
		int pause;
		for (int phase = 0; phase < 6; phase++) begin
			pause = $urandom_range(20, 400);
			v.trig = $urandom_range(0, 100);
			v.on_time = $urandom_range(0, pause + pause / 2);
			v.pause = pause;
			v.sw_thr = $urandom_range(0, 800);
			// a window holds at most a handful of starts here, so no lockout
			v.max_act = $urandom_range(8, 15);
			v.mult = (phase == 0) ? 0 : $urandom_range(1, 3);
			v.grace = $urandom_range(0, pause / 2);
			idle_en = (phase != 5);
			load_setting(v, 1'b0);
			repeat (140) send_sample(random_sample(pause / 3));
		end
	endtask

	task automatic test_lockout();
		reg_values_t v;
		idle_en = 1'b0;
		v = '{trig: 0, on_time: 0, pause: 0, sw_thr: 0, max_act: 15, mult: 0, grace: 5};
		load_setting(v, 1'b0);
		now_ms += 1000;
		// repeated timestamp keeps every start inside the window until the count saturates
		repeat (18) send_sample(timed(0, 10000, 1, 4095, 0));
		v.max_act = 0;
		load_setting(v, 1'b0);
		send_sample(timed(3, 10000, 1, 4095, 0));
		send_sample(timed(1, 10000, 0, 0, 1));
		send_sample(timed(1, 10000, 1, 0, 1));
		send_sample(timed(100, 0, 1, 4095, 0));
		send_sample(timed(32'h8000_0000, 10000, 1, 4095, 0));
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 5);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		fan_status_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got.fan = m_tdata[OUT_FAN];
			got.locked = m_tdata[OUT_LOCK];
			got.pausing = m_tdata[OUT_PAUSE];
			got.starts = m_tdata[OUT_CNT_LO +: CNT_W];
			if (expected_status.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("result without a sample at %0t: %h", $time, m_tdata);
			end else begin
				want = expected_status.pop_front();
				if (got.fan != want.fan || got.locked != want.locked ||
						got.pausing != want.pausing || got.starts != want.starts) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("mismatch at %0t: expected fan %b lock %b pause %b count %0d",
							$time, want.fan, want.locked, want.pausing, want.starts);
						$display("  got fan %b lock %b pause %b count %0d",
							got.fan, got.locked, got.pausing, got.starts);
					end
				end
			end
		end
	end

	initial begin
		#3ms;
		$display("timeout with %0d results outstanding", expected_status.size());
		$display("simulation failed");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_register_extremes();
		test_random_settings();
		test_lockout();
		wait_drained();
		repeat (8) @(posedge clk);
		if (expected_status.size() != 0)
			mismatch_count++;
		$display("%0d samples over %0d register settings, %0d fan starts, %0d mismatches",
			samples_sent, settings_loaded, fan_starts, mismatch_count);
		$display("lockout %s", enabled ? "not reached" : "reached and held to the end");
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
